// File: hw/rtl/bfill8_pkg.sv
// ----------------------------------------------------------------------------
// bfill8_pkg: shared definitions for the 8-connected boundary fill block
// Command codes, register indexes, field widths, default geometry and the
// neighbor step tables used by the fill sequencer.
// ----------------------------------------------------------------------------
package bfill8_pkg;

   // Fixed widths of the command and result words.
   localparam int COORD_W       = 7;
   localparam int FIELD_COLOR_W = 4;
   localparam int COUNT_W       = 15;
   localparam int CMD_W         = 2;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Default geometry of the frame and the pending stack.
   localparam int DEF_FRAME_WIDTH  = 128;
   localparam int DEF_FRAME_HEIGHT = 128;
   localparam int DEF_COLOR_BITS   = 4;
   localparam int DEF_STACK_DEPTH  = 4096;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Register indexes, taken from address bit 2.
   localparam logic REG_FILL_COLOR     = 1'b0;
   localparam logic REG_BOUNDARY_COLOR = 1'b1;

   // Register reset values before masking to the pixel width.
   localparam logic [FIELD_COLOR_W-1:0] RESET_FILL_COLOR     = 4'd14;
   localparam logic [FIELD_COLOR_W-1:0] RESET_BOUNDARY_COLOR = 4'd15;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef logic signed [1:0] step_type;

   // Neighbor offsets. The sequencer issues index 7 first and index 0 last,
   // so pending pixels pop as right, left, down, up and then the diagonals.
   localparam step_type STEP_DX [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                        2'sd1, -2'sd1, 2'sd1, -2'sd1};
   localparam step_type STEP_DY [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                        2'sd1, -2'sd1, -2'sd1, 2'sd1};

endpackage

// File: hw/rtl/boundary_fill_8_connected.sv
// ----------------------------------------------------------------------------
// boundary_fill_8_connected: pixel frame store with an 8-connected fill engine
// Holds a frame of colored pixels in one synchronous memory and spreads a
// fill from a seed pixel through a pending stack held in a second memory.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the req_ channel is a command. A write stores one pixel and
// returns nothing. A read returns the pixel color on the rsp_ channel. A fill
// paints the seed with the fill color and spreads to all eight neighbors until
// it meets boundary or fill colored pixels or the frame edge; its response
// word carries the number of painted pixels and the stack overflow flag.
// A fill works pass by pass: one pass pops an entry, fetches its pixel,
// paints it, and then sweeps the eight neighbors through the single frame
// read port, one neighbor per cycle; a stale entry ends its pass unpainted.
// Items are handled one at a time; req_stall is low only while the
// sequencer is idle.
// A finished response sits in an output register, so the next command is
// taken while rsp_stall holds the previous word; a further response then waits
// until that register is free.
// After reset the block sweeps the frame memory to zero, one pixel a cycle,
// through all FRAME_WIDTH*FRAME_HEIGHT pixels, with req_stall held high. The
// csr_ port takes register writes at any time, including during that sweep.
// ----------------------------------------------------------------------------
module boundary_fill_8_connected
   import bfill8_pkg::*;
#(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
   parameter int COLOR_BITS   = DEF_COLOR_BITS,
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [COORD_W-1:0]       req_x_coord,
   input  logic [COORD_W-1:0]       req_y_coord,
   input  logic [FIELD_COLOR_W-1:0] req_pixel_value,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [FIELD_COLOR_W-1:0] rsp_read_color,
   output logic [COUNT_W-1:0]       rsp_painted_count,
   output logic                     rsp_stack_overflow,

   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   // Derived geometry.
   localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW     = $clog2(PIXELS);
   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int SAW    = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int SE_W   = XW + YW;

   // Sequencer states.
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RDWAIT = 4'd2;
   localparam logic [3:0] S_SEED   = 4'd3;
   localparam logic [3:0] S_POP    = 4'd4;
   localparam logic [3:0] S_FETCH  = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_NBR    = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   // Register field to pixel width; bits above the field read as zero.
   function automatic logic [COLOR_BITS-1:0] to_pixel(input logic [FIELD_COLOR_W-1:0] v);
      logic [COLOR_BITS-1:0] r;
      for (int i = 0; i < COLOR_BITS; i++) begin
         r[i] = (i < FIELD_COLOR_W) ? v[i % FIELD_COLOR_W] : 1'b0;
      end
      return r;
   endfunction

   // Pixel to the 4-bit result field.
   function automatic logic [FIELD_COLOR_W-1:0] to_field(input logic [COLOR_BITS-1:0] p);
      logic [FIELD_COLOR_W-1:0] r;
      for (int i = 0; i < FIELD_COLOR_W; i++) begin
         r[i] = (i < COLOR_BITS) ? p[i % COLOR_BITS] : 1'b0;
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
      return AW'(y) * AW'(FRAME_WIDTH) + AW'(x);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers. Colors are kept masked to the pixel width so
   // that a read back shows what the fill actually compares against.
   // ------------------------------------------------------------------------
   logic [FIELD_COLOR_W-1:0] fill_color_ff, fill_color_in;
   logic [FIELD_COLOR_W-1:0] bnd_color_ff, bnd_color_in;
   logic                     cfg_write;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      fill_color_in = fill_color_ff;
      bnd_color_in  = bnd_color_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_FILL_COLOR: begin
               fill_color_in = to_field(to_pixel(csr_pwdata[FIELD_COLOR_W-1:0]));
            end
            REG_BOUNDARY_COLOR: begin
               bnd_color_in = to_field(to_pixel(csr_pwdata[FIELD_COLOR_W-1:0]));
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FILL_COLOR:     csr_prdata = CSR_DATA_W'(fill_color_ff);
         REG_BOUNDARY_COLOR: csr_prdata = CSR_DATA_W'(bnd_color_ff);
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer state and datapath registers.
   // ------------------------------------------------------------------------
   logic [3:0]               state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [SP_W-1:0]          sp_ff, sp_in;
   logic [2:0]               k_ff, k_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     chk_valid_ff, chk_valid_in;
   logic [XW-1:0]            chk_x_ff, chk_x_in;
   logic [YW-1:0]            chk_y_ff, chk_y_in;
   logic [XW-1:0]            cur_x_ff, cur_x_in;
   logic [YW-1:0]            cur_y_ff, cur_y_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic [FIELD_COLOR_W-1:0] res_color_ff, res_color_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FIELD_COLOR_W-1:0] rsp_color_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_ovf_ff;
   logic                     rsp_load;

   // Memory ports.
   logic [COLOR_BITS-1:0]    frame_mem [PIXELS];
   logic [COLOR_BITS-1:0]    frame_rd_ff;
   logic                     frame_we;
   logic [AW-1:0]            frame_wa;
   logic [COLOR_BITS-1:0]    frame_wd;
   logic [AW-1:0]            frame_ra;
   logic [XW-1:0]            wr_x, rd_x;
   logic [YW-1:0]            wr_y, rd_y;

   logic [SE_W-1:0]          stack_mem [STACK_DEPTH];
   logic [SE_W-1:0]          stack_rd_ff;
   logic                     stack_we;
   logic [SE_W-1:0]          stack_wd;
   logic [SP_W-1:0]          sp_dec;

   // Command decode helpers.
   logic                     req_accept;
   logic                     req_inside;
   logic [XW-1:0]            req_x;
   logic [YW-1:0]            req_y;

   // Neighbor address generation.
   logic [XW:0]              nx_sum;
   logic [YW:0]              ny_sum;
   logic                     n_inside;

   logic [COLOR_BITS-1:0]    fill_px;
   logic [COLOR_BITS-1:0]    bnd_px;
   logic                     rd_paintable;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_inside = (32'(req_x_coord) < FRAME_WIDTH) && (32'(req_y_coord) < FRAME_HEIGHT);
   assign req_x      = XW'(req_x_coord);
   assign req_y      = YW'(req_y_coord);

   assign nx_sum   = {1'b0, cur_x_ff} + (XW+1)'(STEP_DX[k_ff]);
   assign ny_sum   = {1'b0, cur_y_ff} + (YW+1)'(STEP_DY[k_ff]);
   assign n_inside = (32'(nx_sum) < FRAME_WIDTH) && (32'(ny_sum) < FRAME_HEIGHT);

   assign fill_px      = to_pixel(fill_color_ff);
   assign bnd_px       = to_pixel(bnd_color_ff);
   // A pixel may be painted unless it already holds the boundary or fill color.
   assign rd_paintable = (frame_rd_ff != bnd_px) && (frame_rd_ff != fill_px);

   assign sp_dec = sp_ff - SP_W'(1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      sp_in         = sp_ff;
      k_in          = k_ff;
      issue_done_in = issue_done_ff;
      chk_valid_in  = chk_valid_ff;
      chk_x_in      = chk_x_ff;
      chk_y_in      = chk_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      res_color_in  = res_color_ff;
      rsp_load      = 1'b0;

      frame_we = 1'b0;
      frame_wd = to_pixel(req_pixel_value);
      wr_x     = req_x;
      wr_y     = req_y;
      rd_x     = req_x;
      rd_y     = req_y;
      stack_we = 1'b0;
      stack_wd = {cur_y_ff, cur_x_ff};

      unique case (state_ff)
         S_CLEAR: begin
            frame_we = 1'b1;
            frame_wd = '0;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == AW'(PIXELS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               unique case (req_command)
                  CMD_WRITE: begin
                     frame_we = req_inside;
                  end
                  CMD_FILL: begin
                     count_in     = '0;
                     ovf_in       = 1'b0;
                     res_color_in = '0;
                     cur_x_in     = req_x;
                     cur_y_in     = req_y;
                     state_in     = req_inside ? S_SEED : S_EMIT;
                  end
                  CMD_READ: begin
                     count_in     = '0;
                     ovf_in       = 1'b0;
                     res_color_in = '0;
                     state_in     = req_inside ? S_RDWAIT : S_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RDWAIT: begin
            res_color_in = to_field(frame_rd_ff);
            state_in     = S_EMIT;
         end

         S_SEED: begin
            // The stack is empty here, so the seed push cannot overflow.
            if (rd_paintable) begin
               stack_we = 1'b1;
               sp_in    = SP_W'(1);
               state_in = S_POP;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_POP: begin
            if (sp_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               sp_in    = sp_dec;
               state_in = S_FETCH;
            end
         end

         S_FETCH: begin
            rd_x     = stack_rd_ff[XW-1:0];
            rd_y     = stack_rd_ff[SE_W-1:XW];
            cur_x_in = stack_rd_ff[XW-1:0];
            cur_y_in = stack_rd_ff[SE_W-1:XW];
            state_in = S_CHECK;
         end

         S_CHECK: begin
            // The pixel may have been painted since it was pushed.
            if (rd_paintable) begin
               frame_we      = 1'b1;
               frame_wd      = fill_px;
               wr_x          = cur_x_ff;
               wr_y          = cur_y_ff;
               count_in      = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
               k_in          = 3'd7;
               issue_done_in = 1'b0;
               chk_valid_in  = 1'b0;
               state_in      = S_NBR;
            end else begin
               state_in = S_POP;
            end
         end

         S_NBR: begin
            // Issue one neighbor read per cycle and test the one issued
            // in the cycle before; neighbors outside the frame are skipped.
            rd_x = nx_sum[XW-1:0];
            rd_y = ny_sum[YW-1:0];
            if (!issue_done_ff) begin
               chk_valid_in  = n_inside;
               chk_x_in      = nx_sum[XW-1:0];
               chk_y_in      = ny_sum[YW-1:0];
               k_in          = k_ff - 3'd1;
               issue_done_in = (k_ff == 3'd0);
            end else begin
               chk_valid_in = 1'b0;
               state_in     = S_POP;
            end
            stack_wd = {chk_y_ff, chk_x_ff};
            if (chk_valid_ff && rd_paintable) begin
               if (sp_ff == SP_W'(STACK_DEPTH)) begin
                  // Full stack: abandon the fill and drop what is pending.
                  ovf_in   = 1'b1;
                  sp_in    = '0;
                  state_in = S_EMIT;
               end else begin
                  stack_we = 1'b1;
                  sp_in    = sp_ff + SP_W'(1);
               end
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      frame_wa = (state_ff == S_CLEAR) ? clr_ff : addr_of(wr_x, wr_y);
      frame_ra = addr_of(rd_x, rd_y);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         sp_ff         <= '0;
         k_ff          <= '0;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_color_ff <= to_field(to_pixel(RESET_FILL_COLOR));
         bnd_color_ff  <= to_field(to_pixel(RESET_BOUNDARY_COLOR));
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         sp_ff         <= sp_in;
         k_ff          <= k_in;
         issue_done_ff <= issue_done_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_color_ff <= fill_color_in;
         bnd_color_ff  <= bnd_color_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_x_ff     <= chk_x_in;
      chk_y_ff     <= chk_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      count_ff     <= count_in;
      ovf_ff       <= ovf_in;
      res_color_ff <= res_color_in;
      if (rsp_load) begin
         rsp_color_ff <= res_color_ff;
         rsp_count_ff <= count_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // Frame memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_wa] <= frame_wd;
      end
      frame_rd_ff <= frame_mem[frame_ra];
   end

   // Pending stack: pushes write at the stack pointer, pops read just below.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sp_ff[SAW-1:0]] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[sp_dec[SAW-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_color     = rsp_color_ff;
   assign rsp_painted_count  = rsp_count_ff;
   assign rsp_stack_overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_sp_bounded: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_idle_stack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (sp_ff == '0))
      else $error("pending entries left over after a command");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      stack_we |-> (sp_ff < SP_W'(STACK_DEPTH)))
      else $error("push into a full stack");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("response register overwritten while stalled");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("response raised outside the emit state");
`endif

endmodule

// File: tb/tb_boundary_fill_8_connected.sv
// ----------------------------------------------------------------------------
// tb_boundary_fill_8_connected: regression bench for the 8-connected fill block
// Drives pixel writes, reads and fills on the req_ channel and sets the two
// color registers over the csr_ port. A local copy of the frame store and of
// the fill engine predicts every response word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_boundary_fill_8_connected;
   import bfill8_pkg::*;

   localparam int FRAME_W      = DEF_FRAME_WIDTH;
   localparam int FRAME_H      = DEF_FRAME_HEIGHT;
   localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
   localparam int STACK_SLOTS  = DEF_STACK_DEPTH;

   // Command code 3 has no meaning; the block must swallow it silently.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // A pixel write owes no response word, so a short pause before a register
   // write lets it land; the closing pause covers a trailing write as well.
   localparam int WRITE_SETTLE = 20;
   localparam int END_SETTLE   = 100;

   // Neighbor offsets. They are pushed from the last entry down to the first,
   // so pending pixels pop as right, left, down, up and then the diagonals.
   localparam int NB_DX [8] = '{1, -1, 0, 0, 1, -1, 1, -1};
   localparam int NB_DY [8] = '{0, 0, 1, -1, 1, -1, -1, 1};

   typedef struct packed {
      logic [FIELD_COLOR_W-1:0] color;
      logic [COUNT_W-1:0]       count;
      logic                     overflow;
   } reply_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command;
   logic [COORD_W-1:0]       req_x_coord;
   logic [COORD_W-1:0]       req_y_coord;
   logic [FIELD_COLOR_W-1:0] req_pixel_value;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [FIELD_COLOR_W-1:0] rsp_read_color;
   logic [COUNT_W-1:0]       rsp_painted_count;
   logic                     rsp_stack_overflow;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // Local copy of the block's state: the frame, the pending stack of the
   // fill in progress and the two color registers.
   bit [FIELD_COLOR_W-1:0] canvas [FRAME_PIXELS];
   int                     seed_stack [STACK_SLOTS];
   int                     seed_top;
   logic [3:0]             paint_color = RESET_FILL_COLOR;
   logic [3:0]             stop_color  = RESET_BOUNDARY_COLOR;

   reply_word_type owed_replies [$];
   reply_word_type oldest;
   int             commands_sent  = 0;
   int             mismatches     = 0;
   int             sender_gap_pct = 0;
   int             sink_stall_pct = 0;

   boundary_fill_8_connected dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // A pixel may be painted, or pushed, only while it holds neither stop color.
   function automatic bit paintable(int idx);
      return canvas[idx] != stop_color && canvas[idx] != paint_color;
   endfunction

   // Returns 0 only when a paintable in-frame pixel finds the stack full.
   function automatic bit push_seed(int x, int y);
      int idx;
      if (x < 0 || y < 0 || x >= FRAME_W || y >= FRAME_H) return 1'b1;
      idx = y * FRAME_W + x;
      if (!paintable(idx)) return 1'b1;
      if (seed_top >= STACK_SLOTS) return 1'b0;
      seed_stack[seed_top] = idx;
      seed_top++;
      return 1'b1;
   endfunction

   // Applies one accepted command to the local frame and queues the response
   // word it owes, if any. Coordinates are 7 bits wide, so every command lands
   // inside the 128 by 128 frame.
   function automatic void predict_word(logic [CMD_W-1:0] cmd, int x, int y,
                                        logic [3:0] value);
      int             idx;
      int             painted;
      int             px;
      int             py;
      int             k;
      bit             over;
      reply_word_type reply;
      reply = '0;
      idx = y * FRAME_W + x;
      case (cmd)
         CMD_WRITE: begin
            canvas[idx] = value;
         end
         CMD_READ: begin
            reply.color = canvas[idx];
            owed_replies.push_back(reply);
         end
         CMD_FILL: begin
            painted = 0;
            over = 1'b0;
            seed_top = 0;
            if (!push_seed(x, y)) over = 1'b1;
            while (seed_top > 0 && !over) begin
               seed_top--;
               idx = seed_stack[seed_top];
               if (paintable(idx)) begin
                  canvas[idx] = paint_color;
                  painted++;
                  px = idx % FRAME_W;
                  py = idx / FRAME_W;
                  for (k = 7; k >= 0; k--) begin
                     if (!push_seed(px + NB_DX[k], py + NB_DY[k])) begin
                        // A full stack ends the fill at once; painted pixels stay.
                        over = 1'b1;
                        break;
                     end
                  end
               end
            end
            seed_top = 0;
            reply.count = (painted > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(painted);
            reply.overflow = over;
            owed_replies.push_back(reply);
         end
         default: ;
      endcase
   endfunction

   // Sends one command word, with an optional gap first, and holds it until the
   // block takes it. Valid is left high so that a following word goes out
   // back to back; whoever stops sending lowers it.
   task automatic issue_command(logic [CMD_W-1:0] cmd, int x, int y, int value);
      if ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_x_coord     <= x[COORD_W-1:0];
      req_y_coord     <= y[COORD_W-1:0];
      req_pixel_value <= value[FIELD_COLOR_W-1:0];
      do @(posedge clock); while (req_stall);
      predict_word(cmd, x, y, value[3:0]);
      if (cmd != CMD_UNUSED) commands_sent++;
   endtask

   // One APB write followed by a readback of the same register.
   task automatic write_register(logic reg_idx, int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_idx == REG_FILL_COLOR) paint_color = value[3:0];
      else stop_color = value[3:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) note_mismatch("register readback", csr_prdata, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only while the block is idle: every owed word has come
   // back and a trailing pixel write has had time to land.
   task automatic set_colors(int fill, int boundary);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (WRITE_SETTLE) @(posedge clock);
      write_register(REG_FILL_COLOR, fill);
      write_register(REG_BOUNDARY_COLOR, boundary);
   endtask

   // Draws a closed rectangular wall, scatters a few pixels inside, fills from
   // a seed (now and then on the wall itself) and reads back part of the box.
   // A solid rectangle also blocks diagonal leaks, so fills stay small. The
   // wall is sometimes drawn in the fill color, which stops the spread too.
   task automatic paint_region();
      int         w;
      int         h;
      int         x0;
      int         y0;
      int         i;
      int         n;
      int         sx;
      int         sy;
      logic [3:0] wall;
      w = $urandom_range(3, 6);
      h = $urandom_range(3, 6);
      x0 = $urandom_range(0, FRAME_W - w);
      y0 = $urandom_range(0, FRAME_H - h);
      wall = ($urandom_range(3) == 0) ? paint_color : stop_color;
      for (i = 0; i < w; i++) begin
         issue_command(CMD_WRITE, x0 + i, y0, wall);
         issue_command(CMD_WRITE, x0 + i, y0 + h - 1, wall);
      end
      for (i = 1; i < h - 1; i++) begin
         issue_command(CMD_WRITE, x0, y0 + i, wall);
         issue_command(CMD_WRITE, x0 + w - 1, y0 + i, wall);
      end
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
         issue_command(CMD_WRITE, $urandom_range(x0 + 1, x0 + w - 2),
                       $urandom_range(y0 + 1, y0 + h - 2), $urandom_range(15));
      end
      if ($urandom_range(7) == 0) begin
         sx = x0;
         sy = y0 + $urandom_range(h - 1);
      end else begin
         sx = $urandom_range(x0 + 1, x0 + w - 2);
         sy = $urandom_range(y0 + 1, y0 + h - 2);
      end
      issue_command(CMD_FILL, sx, sy, $urandom_range(15));
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
         issue_command(CMD_READ, $urandom_range(x0, x0 + w - 1),
                       $urandom_range(y0, y0 + h - 1), $urandom_range(15));
      end
   endtask

   // Plain pixel access: the cleared frame, both color extremes, the unused
   // command and a fill whose seed already holds the boundary color.
   task automatic test_pixel_access();
      issue_command(CMD_READ, 5, 77, 0);
      issue_command(CMD_WRITE, 0, 0, 15);
      issue_command(CMD_READ, 0, 0, 0);
      issue_command(CMD_WRITE, 127, 0, 7);
      issue_command(CMD_WRITE, 127, 0, 0);
      issue_command(CMD_READ, 127, 0, 15);
      issue_command(CMD_UNUSED, 127, 0, 9);
      issue_command(CMD_READ, 127, 0, 0);
      issue_command(CMD_FILL, 0, 0, 0);
   endtask

   // A fill boxed into the bottom right corner: its neighbors past the frame
   // edge must be clipped. A second fill on a pixel that already holds the
   // fill color paints nothing.
   task automatic test_corner_clip();
      issue_command(CMD_WRITE, 127, 127, 10);
      issue_command(CMD_WRITE, 125, 127, RESET_BOUNDARY_COLOR);
      issue_command(CMD_WRITE, 125, 126, RESET_BOUNDARY_COLOR);
      issue_command(CMD_WRITE, 125, 125, RESET_BOUNDARY_COLOR);
      issue_command(CMD_WRITE, 126, 125, RESET_BOUNDARY_COLOR);
      issue_command(CMD_WRITE, 127, 125, RESET_BOUNDARY_COLOR);
      issue_command(CMD_FILL, 127, 127, 0);
      issue_command(CMD_READ, 126, 126, 0);
      issue_command(CMD_FILL, 126, 126, 0);
   endtask

   // A seed in the open, cleared frame pushes far more neighbors than the
   // stack holds, so the fill must stop early and flag the overflow.
   task automatic test_stack_overflow();
      issue_command(CMD_FILL, 64, 64, 0);
      issue_command(CMD_READ, 64, 64, 0);
   endtask

   // Random phase: most words belong to boxed fills, the rest are loose
   // writes, reads, unused commands and the odd open fill.
   task automatic test_random_regions(int fill, int boundary, int gap_pct,
                                      int stall_pct, int words);
      int first;
      int pick;
      set_colors(fill, boundary);
      sender_gap_pct = gap_pct;
      sink_stall_pct = stall_pct;
      first = commands_sent;
      while (commands_sent - first < words) begin
         if ($urandom_range(99) < 55) begin
            paint_region();
         end else begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               issue_command(CMD_WRITE, $urandom_range(127), $urandom_range(127),
                             $urandom_range(15));
            end else if (pick < 82) begin
               issue_command(CMD_READ, $urandom_range(127), $urandom_range(127),
                             $urandom_range(15));
            end else if (pick < 94) begin
               issue_command(CMD_UNUSED, $urandom_range(127), $urandom_range(127),
                             $urandom_range(15));
            end else begin
               issue_command(CMD_FILL, $urandom_range(127), $urandom_range(127),
                             $urandom_range(15));
            end
         end
      end
   endtask

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   // Every accepted response word is matched against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_replies.size() == 0) begin
            note_mismatch("response word with none owed", rsp_painted_count, 0);
         end else begin
            oldest = owed_replies.pop_front();
            if (rsp_read_color !== oldest.color)
               note_mismatch("read_color", rsp_read_color, oldest.color);
            if (rsp_painted_count !== oldest.count)
               note_mismatch("painted_count", rsp_painted_count, oldest.count);
            if (rsp_stack_overflow !== oldest.overflow)
               note_mismatch("stack_overflow", rsp_stack_overflow, oldest.overflow);
         end
      end
   end

   initial begin
      req_valid       <= 1'b0;
      req_command     <= CMD_WRITE;
      req_x_coord     <= '0;
      req_y_coord     <= '0;
      req_pixel_value <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      sender_gap_pct = 23;
      sink_stall_pct = 86;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed tests run on the reset colors; the block holds req_stall
      // high while it clears the frame, and the first word simply waits.
      test_pixel_access();
      test_corner_clip();
      test_stack_overflow();

      // The first two phases swap the color extremes; the third gives both
      // registers the same color.
      test_random_regions(0, 15, 23, 86, 15);
      test_random_regions(15, 0, 86, 23, 15);
      test_random_regions(6, 6, 0, 0, 15);
      test_random_regions(5, 10, 0, 0, 15);

      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("boundary_fill_8_connected regression: pass");
      end else begin
         $display("boundary_fill_8_connected regression: fail");
      end
      $finish;
   end

   // Backstop against a hung handshake. The frame clear and open fills that
   // sweep the whole frame dominate a correct run, which stays well below this.
   initial begin
      #1_000_000_000;
      $display("boundary_fill_8_connected regression: fail");
      $finish;
   end

endmodule
